// ===== src/afba_pkg.sv =====
// ----------------------------------------------------------------------------
// afba_pkg
// Shared types and constants of the aligned free block bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package afba_pkg;

	// default log2 of the map depth in addresses
	localparam int ADDR_BITS_DEF = 10;
	// longest legal prefix of the wide subnet
	localparam int WIDE_PREFIX_MAX = 29;
	// width of an IPv4 address
	localparam int IP_BITS = 32;

	// item kinds
	typedef enum logic [1:0] {
		KIND_MARK  = 2'd0,
		KIND_FIND  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_DONE   = 2'd0,
		STAT_NONE   = 2'd1,
		STAT_REJECT = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_FIND_RD,
		S_FIND_CHK,
		S_MARK_RD,
		S_MARK_WR,
		S_DONE
	} state_t;

	// log2 of the map word width: words of at most 32 bits, at least two words in the map
	function automatic int word_lg(input int addr_bits);
		int r;
		r = (addr_bits > 5) ? 5 : addr_bits - 1;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/afba_map_ram.sv =====
// ----------------------------------------------------------------------------
// afba_map_ram
// Usage map storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module afba_map_ram #(
	parameter int IDX_BITS  = 5,
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [IDX_BITS-1:0]  waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic [IDX_BITS-1:0]  raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [1 << IDX_BITS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/afba_word_unit.sv =====
// ----------------------------------------------------------------------------
// afba_word_unit
// Per-word evaluation shared by the find and mark steps of the sequencer: finds the first
// aligned free block inside one map word and builds the mark mask of a word.
// ----------------------------------------------------------------------------
`default_nettype none

module afba_word_unit #(
	parameter int ADDR_BITS = 10,
	parameter int WORD_LG   = 5
) (
	input  logic [(1 << WORD_LG)-1:0]          word,
	input  logic [ADDR_BITS-WORD_LG-1:0]       word_idx,
	input  logic [$clog2(ADDR_BITS+1)-1:0]     size_lg,
	input  logic [ADDR_BITS-1:0]               span_m1,
	input  logic [ADDR_BITS-1:0]               mark_lo,
	input  logic [ADDR_BITS-1:0]               mark_hi,
	output logic                               hit,
	output logic [WORD_LG-1:0]                 hit_bit,
	output logic                               word_free,
	output logic [(1 << WORD_LG)-1:0]          mark_mask
);

	localparam int WB   = 1 << WORD_LG;
	localparam int LG_W = $clog2(ADDR_BITS + 1);

	logic [WB-1:0]      lad [WORD_LG+1];
	logic [WB-1:0]      lad_sel;
	logic [LG_W-1:0]    lgs;
	logic [WORD_LG-1:0] amask;
	logic [WB-1:0]      cand;

	// free ladder: level k marks aligned groups of 2^k free bits
	always_comb begin
		lad[0] = ~word;
		for (int k = 1; k <= WORD_LG; k++) begin
			for (int j = 0; j < WB; j++) begin
				if (((j >> (k - 1)) & 1) == 0) begin
					lad[k][j] = lad[k-1][j] & lad[k-1][j + (1 << (k - 1))];
				end else begin
					lad[k][j] = 1'b0;
				end
			end
		end
	end

	// block size clipped to one word
	assign lgs = (size_lg > LG_W'(WORD_LG)) ? LG_W'(WORD_LG) : size_lg;
	assign amask = ~({WORD_LG{1'b1}} << lgs);

	always_comb begin
		lad_sel = '0;
		for (int k = 0; k <= WORD_LG; k++) begin
			if (lgs == LG_W'(k)) begin
				lad_sel = lad[k];
			end
		end
	end

	// aligned, free and inside the wide span
	always_comb begin
		for (int j = 0; j < WB; j++) begin
			cand[j] = lad_sel[j] && ((WORD_LG'(j) & amask) == '0) &&
				({word_idx, WORD_LG'(j)} <= span_m1);
		end
	end

	// lowest candidate wins
	always_comb begin
		hit_bit = '0;
		for (int j = WB - 1; j >= 0; j--) begin
			if (cand[j]) begin
				hit_bit = WORD_LG'(j);
			end
		end
	end

	assign hit       = |cand;
	assign word_free = (word == '0);

	// bits of this word that fall in [mark_lo, mark_hi]
	always_comb begin
		for (int j = 0; j < WB; j++) begin
			mark_mask[j] = ({word_idx, WORD_LG'(j)} >= mark_lo) &&
				({word_idx, WORD_LG'(j)} <= mark_hi);
		end
	end

endmodule

`default_nettype wire

// ===== src/aligned_free_block_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// aligned_free_block_bitmap_allocator
// First-fit allocator of aligned IPv4 subnets over a usage bitmap of a wide
// subnet. Mark, find-and-allocate and clear items, one status result each.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  in       | in_valid / in_stall    | kind, subnet_address, prefix_len
//  out      | out_valid / out_stall  | status, found_address, found_prefix_len
//  cfg      | cfg_write_en           | cfg_index, cfg_data
//
//  Map is held in 2^ADDR_BITS/32 words (32 at default) of one single-port-write
//  RAM; find steps read through the shared word unit, mark steps are read-modify-writes through it.
//  Mark: a read and a write-back per map word touched. Find: a read per word
//  scanned, then the mark of the found block. Rejected items go straight to
//  the result. Clear: one write per map word, then the result.
//  After reset a clearing pass over every map word runs before the
//  first item is taken. A stalled result holds; the next item is taken
//  meanwhile and finishes once the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module aligned_free_block_bitmap_allocator #(
	parameter int ADDR_BITS = afba_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// item channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] subnet_address,
	input  logic [5:0]  prefix_len,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] found_address,
	output logic [5:0]  found_prefix_len
);

	localparam int WORD_LG  = afba_pkg::word_lg(ADDR_BITS);
	localparam int WB       = 1 << WORD_LG;
	localparam int WIDX     = ADDR_BITS - WORD_LG;
	localparam int LG_W     = $clog2(ADDR_BITS + 1);
	localparam int WIDE_MIN = afba_pkg::IP_BITS - ADDR_BITS;

	afba_pkg::state_t  state_q, state_d;
	afba_pkg::status_t res_status_q;

	// configuration registers
	logic [31:0] base_q;
	logic [4:0]  wpl_q;

	// item registers
	logic [1:0]      kind_q;
	logic [5:0]      plen_q;
	logic [31:0]     off_q;
	logic [LG_W-1:0] slg_q;

	// sequencer registers
	logic [WIDX-1:0]      w_q;
	logic [ADDR_BITS-1:0] lo_q, hi_q;
	logic                 dirty_q;
	logic                 found_q;
	logic                 clr_resp_q;

	// output registers
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [31:0] found_q_addr;
	logic [5:0]  fplen_q;

	// map and word unit
	logic            ram_we;
	logic [WB-1:0]   ram_wdata, ram_rdata, mark_mask;
	logic            hit, word_free;
	logic [WORD_LG-1:0] hit_bit;

	// derived values
	logic [5:0]           span_lg;
	logic [ADDR_BITS-1:0] span_m1, size_m1, lo_find, mark_hi_sum;
	logic [WIDX-1:0]      last_w, blk_mask_w, hi_w;
	logic                 wide_ok, chk_reject, mark_fits, small_blk;
	logic                 blk_end, find_hit, out_load, in_xfer;

	// ------------------------------------------------------------------
	// derived geometry
	// ------------------------------------------------------------------
	assign span_lg   = 6'd32 - {1'b0, wpl_q};
	assign span_m1   = ~({ADDR_BITS{1'b1}} << LG_W'(span_lg));
	assign size_m1   = ~({ADDR_BITS{1'b1}} << slg_q);
	assign last_w    = span_m1[ADDR_BITS-1:WORD_LG];
	assign blk_mask_w = size_m1[ADDR_BITS-1:WORD_LG];
	assign hi_w      = hi_q[ADDR_BITS-1:WORD_LG];
	assign wide_ok   = ({1'b0, wpl_q} >= 6'(WIDE_MIN)) &&
		({1'b0, wpl_q} <= 6'(afba_pkg::WIDE_PREFIX_MAX));
	assign chk_reject = (kind_q != afba_pkg::KIND_MARK && kind_q != afba_pkg::KIND_FIND) ||
		!wide_ok || (plen_q > 6'd32) || (plen_q < {1'b0, wpl_q});
	assign mark_fits = off_q <= 32'(span_m1 - size_m1);
	assign mark_hi_sum = off_q[ADDR_BITS-1:0] + size_m1;

	// find decision on the word just read
	assign small_blk = slg_q <= LG_W'(WORD_LG);
	assign blk_end   = (w_q & blk_mask_w) == blk_mask_w;
	assign find_hit  = small_blk ? hit : (blk_end && word_free && !dirty_q);
	assign lo_find   = small_blk ? {w_q, hit_bit} : ({w_q, {WORD_LG{1'b0}}} & ~size_m1);

	assign in_xfer  = in_valid && !in_stall;
	assign out_load = (state_q == afba_pkg::S_DONE) && (!out_valid_q || !out_stall);

	// ------------------------------------------------------------------
	// map memory and shared word unit
	// ------------------------------------------------------------------
	afba_map_ram #(
		.IDX_BITS (WIDX),
		.WORD_BITS(WB)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(w_q),
		.wdata(ram_wdata),
		.raddr(w_q),
		.rdata(ram_rdata)
	);

	afba_word_unit #(
		.ADDR_BITS(ADDR_BITS),
		.WORD_LG  (WORD_LG)
	) u_word (
		.word     (ram_rdata),
		.word_idx (w_q),
		.size_lg  (slg_q),
		.span_m1  (span_m1),
		.mark_lo  (lo_q),
		.mark_hi  (hi_q),
		.hit      (hit),
		.hit_bit  (hit_bit),
		.word_free(word_free),
		.mark_mask(mark_mask)
	);

	// ------------------------------------------------------------------
	// next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			afba_pkg::S_CLEAR: begin
				if (w_q == {WIDX{1'b1}}) begin
					state_d = clr_resp_q ? afba_pkg::S_DONE : afba_pkg::S_IDLE;
				end
			end
			afba_pkg::S_IDLE: begin
				if (in_xfer) begin
					state_d = afba_pkg::S_CHECK;
				end
			end
			afba_pkg::S_CHECK: begin
				if (kind_q == afba_pkg::KIND_CLEAR) begin
					state_d = afba_pkg::S_CLEAR;
				end else if (chk_reject) begin
					state_d = afba_pkg::S_DONE;
				end else if (kind_q == afba_pkg::KIND_MARK) begin
					state_d = mark_fits ? afba_pkg::S_MARK_RD : afba_pkg::S_DONE;
				end else begin
					state_d = afba_pkg::S_FIND_RD;
				end
			end
			afba_pkg::S_FIND_RD:  state_d = afba_pkg::S_FIND_CHK;
			afba_pkg::S_FIND_CHK: begin
				if (find_hit) begin
					state_d = afba_pkg::S_MARK_RD;
				end else if (blk_end && w_q == last_w) begin
					state_d = afba_pkg::S_DONE;
				end else begin
					state_d = afba_pkg::S_FIND_RD;
				end
			end
			afba_pkg::S_MARK_RD:  state_d = afba_pkg::S_MARK_WR;
			afba_pkg::S_MARK_WR: begin
				if (w_q == hi_w) begin
					state_d = afba_pkg::S_DONE;
				end else begin
					state_d = afba_pkg::S_MARK_RD;
				end
			end
			afba_pkg::S_DONE: begin
				if (out_load) begin
					state_d = afba_pkg::S_IDLE;
				end
			end
			default: state_d = afba_pkg::S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer outputs
	// ------------------------------------------------------------------
	always_comb begin
		in_stall  = (state_q != afba_pkg::S_IDLE);
		ram_we    = 1'b0;
		ram_wdata = '0;
		case (state_q)
			afba_pkg::S_CLEAR: begin
				ram_we = 1'b1;
			end
			afba_pkg::S_MARK_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata | mark_mask;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= afba_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			wpl_q  <= 5'd22;
		end else if (cfg_write_en) begin
			if (cfg_index == 1'b0) begin
				base_q <= cfg_data;
			end else begin
				wpl_q <= cfg_data[4:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// item capture
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q <= kind;
			plen_q <= prefix_len;
			off_q  <= subnet_address - base_q;
			slg_q  <= LG_W'(6'd32 - prefix_len);
		end
	end

	// ------------------------------------------------------------------
	// sequencer datapath
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q          <= '0;
			clr_resp_q   <= 1'b0;
			found_q      <= 1'b0;
			dirty_q      <= 1'b0;
			res_status_q <= afba_pkg::STAT_DONE;
			lo_q         <= '0;
			hi_q         <= '0;
		end else begin
			case (state_q)
				afba_pkg::S_CLEAR: begin
					w_q <= w_q + 1'b1;
				end
				afba_pkg::S_CHECK: begin
					found_q      <= 1'b0;
					dirty_q      <= 1'b0;
					res_status_q <= afba_pkg::STAT_REJECT;
					if (kind_q == afba_pkg::KIND_CLEAR) begin
						w_q          <= '0;
						clr_resp_q   <= 1'b1;
						res_status_q <= afba_pkg::STAT_DONE;
					end else if (!chk_reject && kind_q == afba_pkg::KIND_MARK) begin
						if (mark_fits) begin
							lo_q         <= off_q[ADDR_BITS-1:0];
							hi_q         <= mark_hi_sum;
							w_q          <= off_q[ADDR_BITS-1:WORD_LG];
							res_status_q <= afba_pkg::STAT_DONE;
						end
					end else if (!chk_reject) begin
						w_q          <= '0;
						res_status_q <= afba_pkg::STAT_NONE;
					end
				end
				afba_pkg::S_FIND_CHK: begin
					if (find_hit) begin
						lo_q         <= lo_find;
						hi_q         <= lo_find | size_m1;
						w_q          <= lo_find[ADDR_BITS-1:WORD_LG];
						found_q      <= 1'b1;
						res_status_q <= afba_pkg::STAT_DONE;
					end else if (blk_end) begin
						dirty_q <= 1'b0;
						w_q     <= w_q + 1'b1;
					end else begin
						dirty_q <= dirty_q | !word_free;
						w_q     <= w_q + 1'b1;
					end
				end
				afba_pkg::S_MARK_WR: begin
					w_q <= w_q + 1'b1;
				end
				afba_pkg::S_DONE: begin
					clr_resp_q <= 1'b0;
				end
				default: begin
					dirty_q <= dirty_q;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q     <= res_status_q;
			found_q_addr <= found_q ? (base_q + 32'(lo_q)) : 32'd0;
			fplen_q      <= plen_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign found_address    = found_q_addr;
	assign found_prefix_len = fplen_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == afba_pkg::S_CHECK)
		else $error("accepted item did not enter check");

	a_zero_unless_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != afba_pkg::STAT_DONE |-> found_address == 32'd0)
		else $error("address reported without allocation");

	a_mark_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == afba_pkg::S_MARK_WR |->
			(w_q >= lo_q[ADDR_BITS-1:WORD_LG]) && (w_q <= hi_w))
		else $error("mark write outside the marked range");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == afba_pkg::S_DONE && !out_valid |=> out_valid)
		else $error("finished result not presented");

endmodule

`default_nettype wire
